[src/csab_pkg.sv]
package csab_pkg;

    localparam int MAX_FRAME_WIDTH  = 256;
    localparam int MAX_FRAME_HEIGHT = 256;
    localparam int MAX_SPRITE_SIDE  = 256;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [1:0] REQ_BLEND = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_LEFT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_TOP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_HEIGHT = 3'd5;

    localparam logic [7:0] ALPHA_OPAQUE   = 8'd255;
    localparam logic [7:0] ALPHA_SKIP_MAX = 8'd1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic        first_texel;
        logic [7:0]  texel_blue;
        logic [7:0]  texel_green;
        logic [7:0]  texel_red;
        logic [7:0]  texel_alpha;
        logic [15:0] target_pixel;
    } t_in_item;

    typedef struct packed {
        logic [15:0] pixel_index;
        logic [31:0] pixel_value;
        logic        wrote;
        logic        sprite_done;
    } t_out_item;

endpackage

[src/clipped_sprite_alpha_blit_top.sv]
// Channel | Direction | Handshake                   | Payload
// in      | input     | i_in_valid / o_in_stall     | i_in_data  (t_in_item)
// out     | output    | o_out_valid / i_out_stall   | o_out_data (t_out_item)
// cfg     | input     | i_cfg_we, i_cfg_index       | i_cfg_data
//
// One item per cycle while the output is not stalled; a taken item passes through the modify stage
// register into the output register. The frame store is a single-write memory: read at accept,
// modify, write back as the item leaves the modify stage; a same-pixel read at that write gets the
// written value forwarded. Synchronous active-low reset clears the pipeline and texel counters,
// and sets config registers to defaults; the frame store holds whatever it had until a pixel
// is written or cleared. A stall on the output holds the output register; the input stalls only
// when the modify stage is full and cannot drain.
module clipped_sprite_alpha_blit_top import csab_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [2:0] {
        OP_ZERO,
        OP_KEEP,
        OP_COPY,
        OP_MIX,
        OP_CLEAR
    } t_op;

    function automatic logic [7:0] blend_byte(input logic [7:0] d, input logic [7:0] s,
                                              input logic [7:0] a);
        logic signed [8:0]  diff;
        logic signed [17:0] p;
        diff = $signed({1'b0, s}) - $signed({1'b0, d});
        p    = 18'($signed({1'b0, a})) * 18'(diff);
        // low byte of d + (p >>> 8)
        blend_byte = d + p[15:8];
    endfunction

    // config registers
    logic [8:0]  r_frame_width, r_frame_height, r_sprite_width, r_sprite_height;
    logic [15:0] r_sprite_left, r_sprite_top;

    logic [7:0]  r_col, r_row, n_col, n_row;

    logic [31:0] mem [65536];
    logic [31:0] r_rdata;
    logic        r_fwd_hit;
    logic [31:0] r_fwd_data;

    logic        r_s1_valid;
    t_op         r_s1_op;
    logic [15:0] r_s1_idx;
    logic [31:0] r_s1_texel;
    logic        r_s1_done;

    logic        r_out_valid;
    t_out_item   r_out;

    logic        out_free, s1_adv, in_accept, s1_wr_en;
    logic [8:0]  fw, fh, sw, sh;
    logic [7:0]  col0, row0;
    logic [16:0] px, py;
    logic        in_frame;
    logic [16:0] row_base;
    logic [15:0] blend_idx;
    logic        end_col, end_row;
    logic [15:0] rd_addr;
    t_op         in_op;
    logic        in_done;
    logic [31:0] d_cur, s1_val;
    logic        s1_wrote;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_adv     = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    // clamped sizes
    always_comb begin
        fw = (r_frame_width > 9'(MAX_FRAME_WIDTH)) ? 9'(MAX_FRAME_WIDTH) : r_frame_width;
        fh = (r_frame_height > 9'(MAX_FRAME_HEIGHT)) ? 9'(MAX_FRAME_HEIGHT) : r_frame_height;
        if (r_sprite_width == 9'd0) begin
            sw = 9'd1;
        end else if (r_sprite_width > 9'(MAX_SPRITE_SIDE)) begin
            sw = 9'(MAX_SPRITE_SIDE);
        end else begin
            sw = r_sprite_width;
        end
        if (r_sprite_height == 9'd0) begin
            sh = 9'd1;
        end else if (r_sprite_height > 9'(MAX_SPRITE_SIDE)) begin
            sh = 9'(MAX_SPRITE_SIDE);
        end else begin
            sh = r_sprite_height;
        end
    end

    // texel position and clipping
    always_comb begin
        col0      = i_in_data.first_texel ? 8'd0 : r_col;
        row0      = i_in_data.first_texel ? 8'd0 : r_row;
        px        = {r_sprite_left[15], r_sprite_left} + {9'd0, col0};
        py        = {r_sprite_top[15], r_sprite_top} + {9'd0, row0};
        in_frame  = !px[16] && !py[16] &&
                    (px[15:0] < {7'd0, fw}) && (py[15:0] < {7'd0, fh});
        row_base  = {9'd0, py[7:0]} * {8'd0, fw};
        blend_idx = row_base[15:0] + {8'd0, px[7:0]};
        end_col   = ({1'b0, col0} + 9'd1) >= sw;
        end_row   = ({1'b0, row0} + 9'd1) >= sh;
        n_col     = end_col ? 8'd0 : col0 + 8'd1;
        n_row     = end_col ? (end_row ? 8'd0 : row0 + 8'd1) : row0;
    end

    always_comb begin
        rd_addr = 16'd0;
        in_op   = OP_ZERO;
        in_done = 1'b0;
        case (i_in_data.req_type)
            REQ_BLEND: begin
                in_done = end_col && end_row;
                if (in_frame) begin
                    rd_addr = blend_idx;
                    if (i_in_data.texel_alpha == ALPHA_OPAQUE) begin
                        in_op = OP_COPY;
                    end else if (i_in_data.texel_alpha > ALPHA_SKIP_MAX) begin
                        in_op = OP_MIX;
                    end else begin
                        in_op = OP_KEEP;
                    end
                end
            end
            REQ_READ: begin
                rd_addr = i_in_data.target_pixel;
                in_op   = OP_KEEP;
            end
            REQ_CLEAR: begin
                rd_addr = i_in_data.target_pixel;
                in_op   = OP_CLEAR;
            end
            default: begin
                in_op = OP_ZERO;
            end
        endcase
    end

    // modify stage
    always_comb begin
        d_cur    = r_fwd_hit ? r_fwd_data : r_rdata;
        s1_val   = 32'd0;
        s1_wrote = 1'b0;
        case (r_s1_op)
            OP_KEEP: begin
                s1_val = d_cur;
            end
            OP_COPY: begin
                s1_val   = r_s1_texel;
                s1_wrote = 1'b1;
            end
            OP_MIX: begin
                s1_val   = {d_cur[31:24],
                            blend_byte(d_cur[23:16], r_s1_texel[23:16], r_s1_texel[31:24]),
                            blend_byte(d_cur[15:8], r_s1_texel[15:8], r_s1_texel[31:24]),
                            blend_byte(d_cur[7:0], r_s1_texel[7:0], r_s1_texel[31:24])};
                s1_wrote = 1'b1;
            end
            OP_CLEAR: begin
                s1_val   = {d_cur[31:24], 24'd0};
                s1_wrote = 1'b1;
            end
            default: begin
                s1_val = 32'd0;
            end
        endcase
    end

    assign s1_wr_en = i_rst_n && s1_adv && s1_wrote;

    always_ff @(posedge i_clk) begin
        if (s1_wr_en) begin
            mem[r_s1_idx] <= s1_val;
        end
        if (in_accept) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_op    <= in_op;
            r_s1_idx   <= rd_addr;
            r_s1_done  <= in_done;
            r_s1_texel <= {i_in_data.texel_alpha, i_in_data.texel_red,
                           i_in_data.texel_green, i_in_data.texel_blue};
            r_fwd_data <= s1_val;
        end
        if (s1_adv) begin
            r_out.pixel_index <= r_s1_idx;
            r_out.pixel_value <= s1_val;
            r_out.wrote       <= s1_wrote;
            r_out.sprite_done <= r_s1_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_fwd_hit       <= 1'b0;
            r_col           <= 8'd0;
            r_row           <= 8'd0;
            r_frame_width   <= 9'd256;
            r_frame_height  <= 9'd256;
            r_sprite_left   <= 16'd0;
            r_sprite_top    <= 16'd0;
            r_sprite_width  <= 9'd16;
            r_sprite_height <= 9'd16;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
            // the item leaving writes at the same edge the next one reads
            if (in_accept) begin
                r_fwd_hit <= s1_adv && s1_wrote && (rd_addr == r_s1_idx);
            end
            if (in_accept && i_in_data.req_type == REQ_BLEND) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FRAME_WIDTH:   r_frame_width   <= i_cfg_data[8:0];
                    CFG_FRAME_HEIGHT:  r_frame_height  <= i_cfg_data[8:0];
                    CFG_SPRITE_LEFT:   r_sprite_left   <= i_cfg_data;
                    CFG_SPRITE_TOP:    r_sprite_top    <= i_cfg_data;
                    CFG_SPRITE_WIDTH:  r_sprite_width  <= i_cfg_data[8:0];
                    CFG_SPRITE_HEIGHT: r_sprite_height <= i_cfg_data[8:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[src/csab_chk.sv]
module csab_chk import csab_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // input backs up only behind a held output item
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled with output free");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |-> ##2 o_out_valid)
        else $error("accepted item did not reach output");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output item changed");

endmodule

bind clipped_sprite_alpha_blit_top csab_chk u_csab_chk (.*);
